FILE: rtl/smtp_clp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser package
// Shared result codes, character constants, defaults and the types that
// travel between the parser modules.
// ----------------------------------------------------------------------------
package smtp_clp_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_NAME_CHARS_DEF = 32;
  localparam int COUNT_BITS_DEF     = 17;

  // Configuration register indexes and reset values.
  localparam int             CFG_IDX_BITS     = 1;
  localparam logic [0:0]     REG_MAX_PARAM    = 1'b0;
  localparam logic [0:0]     REG_MAX_AUTH     = 1'b1;
  localparam logic [15:0]    MAX_PARAM_RESET  = 16'd4096;
  localparam logic [15:0]    MAX_AUTH_RESET   = 16'd8192;

  // Characters of interest.
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_HT      = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_TXT_LO  = 8'h21;
  localparam logic [7:0] CH_TXT_HI  = 8'h7E;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // Result kinds.
  localparam logic [2:0] KIND_SILENT = 3'd0;
  localparam logic [2:0] KIND_NAME   = 3'd1;
  localparam logic [2:0] KIND_PARAM  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CMD  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // Error causes.
  localparam logic [2:0] CAUSE_NAME_LONG  = 3'd0;
  localparam logic [2:0] CAUSE_AFTER_NAME = 3'd1;
  localparam logic [2:0] CAUSE_DUP_SPACE  = 3'd2;
  localparam logic [2:0] CAUSE_BAD_PARAM  = 3'd3;
  localparam logic [2:0] CAUSE_NO_LF      = 3'd4;
  localparam logic [2:0] CAUSE_PARAM_LONG = 3'd5;

  // Line parsing phase, one-hot.
  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_NAME    = 5'b00010,
    PH_PARAMS  = 5'b00100,
    PH_WANT_LF = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_t;

  // One input item held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       auth;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] trim;
    logic [1:0]  code;
    logic [2:0]  cause;
  } result_t;

  // Limits from the configuration registers.
  typedef struct packed {
    logic [15:0] max_param;
    logic [15:0] max_auth;
  } limits_t;

endpackage

FILE: rtl/smtp_command_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser
// Splits a byte stream of SMTP command lines into name characters,
// parameter bytes, line-complete markers and error reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stream byte per transfer; in_tuser marks an auth response
//           line and is only looked at on the first byte of a line.
//   out_* : exactly one result per input byte. out_tuser carries the kind;
//           out_tdata carries the byte, trim count and error code/cause.
//   cfg_* : writes the parameter and auth length limits; always ready.
//           Write only while no bytes are in flight.
// The result passes through the input register and the result register
// before it shows on out_tvalid. Throughput is one byte per cycle while
// the receiver does not stall, set by the combinational state update in
// the parse core that sits between the input register and the result
// register.
// When the receiver stalls, the result register holds and the input
// register fills; in_tready then drops until out_tready returns.
// Reset empties both registers, returns the parser to line start and sets
// the limits to 4096 and 8192 bytes. There is no clearing pass.
// ----------------------------------------------------------------------------
module smtp_command_line_parser #(
  parameter int MAX_NAME_CHARS = smtp_clp_pkg::MAX_NAME_CHARS_DEF,
  parameter int COUNT_BITS     = smtp_clp_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // [7:0] in_byte
  input  logic                                   in_tuser,   // [0] auth_line
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [7:0] out_byte, [23:8] trim_count, [25:24] err_code,
  // [28:26] error_cause, [31:29] zero
  output logic [31:0]                            out_tdata,
  output logic [2:0]                             out_tuser,  // [2:0] kind
  // Configuration writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smtp_clp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [15:0]                            cfg_data
);
  import smtp_clp_pkg::*;

  limits_t  limits;
  in_item_t item;
  logic     item_valid;
  logic     can_load;
  logic     step;
  result_t  result;

  // A held byte moves into the parser when the result register has room.
  assign step = item_valid && can_load;

  smtp_clp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  smtp_clp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  smtp_clp_core #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .limits (limits),
    .result (result)
  );

  smtp_clp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Only name and parameter results carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_NAME) && (out_tuser != KIND_PARAM)
      |-> (out_tdata[7:0] == 8'd0))
    else $error("byte set on a result without data");

  // A trim count appears only with a line-complete result.
  a_trim_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_DONE) |-> (out_tdata[23:8] == 16'd0))
    else $error("trim count set outside line complete");

  // A stalled result register never accepts a new item from the parser.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !step)
    else $error("parser advanced into a stalled result register");

endmodule

FILE: rtl/smtp_clp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser configuration registers
// Holds the parameter and auth line length limits, written over a simple
// valid/ready channel that never stalls.
// ----------------------------------------------------------------------------
module smtp_clp_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smtp_clp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [15:0]                            cfg_data,
  output smtp_clp_pkg::limits_t                  limits
);
  import smtp_clp_pkg::*;

  logic [15:0] max_param_r;
  logic [15:0] max_auth_r;

  assign cfg_ready = 1'b1;

  // A write transfer updates the addressed limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_param_r <= MAX_PARAM_RESET;
      max_auth_r  <= MAX_AUTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_PARAM: max_param_r <= cfg_data;
        REG_MAX_AUTH:  max_auth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limits.max_param = max_param_r;
  assign limits.max_auth  = max_auth_r;

endmodule

FILE: rtl/smtp_clp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser input register
// Captures one byte and its auth flag per transfer and holds it until the
// parse core takes it.
// ----------------------------------------------------------------------------
module smtp_clp_in_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic                    in_tuser,
  input  logic                    take,
  output logic                    item_valid,
  output smtp_clp_pkg::in_item_t  item
);
  import smtp_clp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Free when empty or when the held item moves on in this cycle.
  assign in_tready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data <= in_tdata;
      item_r.auth <= in_tuser;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/smtp_clp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser core
// Line state registers and the combinational step that classifies one byte,
// updates the counters and forms the result item.
// ----------------------------------------------------------------------------
module smtp_clp_core #(
  parameter int MAX_NAME_CHARS = smtp_clp_pkg::MAX_NAME_CHARS_DEF,
  parameter int COUNT_BITS     = smtp_clp_pkg::COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  smtp_clp_pkg::in_item_t  item,
  input  smtp_clp_pkg::limits_t   limits,
  output smtp_clp_pkg::result_t   result
);
  import smtp_clp_pkg::*;

  localparam int NAME_BITS = $clog2(MAX_NAME_CHARS + 1);
  localparam int CMP_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  phase_t                phase_r, phase_nxt, phase_e;
  logic [NAME_BITS-1:0]  name_cnt_r, name_cnt_nxt, name_cnt_e;
  logic [COUNT_BITS-1:0] param_cnt_r, param_cnt_nxt, param_cnt_e;
  logic [COUNT_BITS-1:0] ws_cnt_r, ws_cnt_nxt, ws_cnt_e;
  logic                  first_sp_r, first_sp_nxt, first_sp_e;
  logic                  seen_txt_r, seen_txt_nxt, seen_txt_e;
  logic                  auth_r, auth_nxt, auth_e;

  logic [7:0]            b;
  logic                  is_upper, is_lower, is_ws, is_text, is_lf;
  logic [15:0]           limit;
  logic                  too_long;
  logic [CMP_BITS-1:0]   ws_ext;
  logic [15:0]           trim;
  phase_t                fail_phase;

  // Byte classes.
  assign b        = item.data;
  assign is_upper = (b >= "A") && (b <= "Z");
  assign is_lower = (b >= "a") && (b <= "z");
  assign is_ws    = (b == CH_SP) || (b == CH_HT);
  assign is_text  = is_ws || ((b >= CH_TXT_LO) && (b <= CH_TXT_HI));
  assign is_lf    = (b == CH_LF);
  assign fail_phase = is_lf ? PH_START : PH_SKIP;

  // State as seen by this byte: a line start clears the line context.
  always_comb begin
    phase_e    = phase_r;
    name_cnt_e = name_cnt_r;
    param_cnt_e = param_cnt_r;
    ws_cnt_e   = ws_cnt_r;
    first_sp_e = first_sp_r;
    seen_txt_e = seen_txt_r;
    auth_e     = auth_r;
    if (phase_r == PH_START) begin
      phase_e     = item.auth ? PH_PARAMS : PH_NAME;
      name_cnt_e  = '0;
      param_cnt_e = '0;
      ws_cnt_e    = '0;
      first_sp_e  = 1'b0;
      seen_txt_e  = 1'b0;
      auth_e      = item.auth;
    end
  end

  // Length limit check; a zero limit means unlimited.
  assign limit    = auth_e ? limits.max_auth : limits.max_param;
  assign too_long = (limit != 16'd0) &&
                    (CMP_BITS'(param_cnt_e) >= CMP_BITS'(limit));

  // Trailing whitespace count, saturated to the 16-bit field.
  assign ws_ext = CMP_BITS'(ws_cnt_e);
  assign trim   = (ws_ext > CMP_BITS'(16'hFFFF)) ? 16'hFFFF : ws_ext[15:0];

  // Per-byte step.
  always_comb begin
    phase_nxt     = phase_e;
    name_cnt_nxt  = name_cnt_e;
    param_cnt_nxt = param_cnt_e;
    ws_cnt_nxt    = ws_cnt_e;
    first_sp_nxt  = first_sp_e;
    seen_txt_nxt  = seen_txt_e;
    auth_nxt      = auth_e;
    result        = '0;
    result.kind   = KIND_SILENT;

    unique case (phase_e)
      PH_NAME: begin
        priority if (is_upper || is_lower) begin
          if (name_cnt_e >= NAME_BITS'(MAX_NAME_CHARS)) begin
            phase_nxt    = fail_phase;
            result.kind  = KIND_ERROR;
            result.code  = ERR_BAD_CMD;
            result.cause = CAUSE_NAME_LONG;
          end else begin
            name_cnt_nxt = name_cnt_e + NAME_BITS'(1);
            result.kind  = KIND_NAME;
            result.data  = is_lower ? (b - CASE_DELTA) : b;
          end
        end else if (b == CH_SP) begin
          phase_nxt = PH_PARAMS;
        end else if (b == CH_CR) begin
          phase_nxt = PH_WANT_LF;
        end else if (is_lf) begin
          phase_nxt   = PH_START;
          result.kind = KIND_DONE;
        end else begin
          phase_nxt    = fail_phase;
          result.kind  = KIND_ERROR;
          result.code  = ERR_BAD_CMD;
          result.cause = CAUSE_AFTER_NAME;
        end
      end

      PH_PARAMS: begin
        priority if (is_text) begin
          if (too_long) begin
            phase_nxt    = fail_phase;
            result.kind  = KIND_ERROR;
            result.code  = ERR_TOO_LONG;
            result.cause = CAUSE_PARAM_LONG;
          end else begin
            if (param_cnt_e == '0) begin
              first_sp_nxt = (b == CH_SP);
            end
            if (param_cnt_e != '1) begin
              param_cnt_nxt = param_cnt_e + COUNT_BITS'(1);
            end
            if (is_ws) begin
              if (ws_cnt_e != '1) begin
                ws_cnt_nxt = ws_cnt_e + COUNT_BITS'(1);
              end
            end else begin
              ws_cnt_nxt   = '0;
              seen_txt_nxt = 1'b1;
            end
            result.kind = KIND_PARAM;
            result.data = b;
          end
        end else if (!auth_e && first_sp_e && seen_txt_e) begin
          phase_nxt    = fail_phase;
          result.kind  = KIND_ERROR;
          result.code  = ERR_BAD_CMD;
          result.cause = CAUSE_DUP_SPACE;
        end else if (b == CH_CR) begin
          phase_nxt = PH_WANT_LF;
        end else if (is_lf) begin
          phase_nxt   = PH_START;
          result.kind = KIND_DONE;
          result.trim = trim;
        end else begin
          phase_nxt    = fail_phase;
          result.kind  = KIND_ERROR;
          result.code  = ERR_BAD_CMD;
          result.cause = CAUSE_BAD_PARAM;
        end
      end

      PH_WANT_LF: begin
        if (is_lf) begin
          phase_nxt   = PH_START;
          result.kind = KIND_DONE;
          result.trim = trim;
        end else begin
          phase_nxt    = PH_SKIP;
          result.kind  = KIND_ERROR;
          result.code  = ERR_BAD_CMD;
          result.cause = CAUSE_NO_LF;
        end
      end

      // Skipping after an error, through the next LF.
      default: begin
        phase_nxt = is_lf ? PH_START : PH_SKIP;
      end
    endcase
  end

  // State registers advance once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      name_cnt_r  <= '0;
      param_cnt_r <= '0;
      ws_cnt_r    <= '0;
      first_sp_r  <= 1'b0;
      seen_txt_r  <= 1'b0;
      auth_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      name_cnt_r  <= name_cnt_nxt;
      param_cnt_r <= param_cnt_nxt;
      ws_cnt_r    <= ws_cnt_nxt;
      first_sp_r  <= first_sp_nxt;
      seen_txt_r  <= seen_txt_nxt;
      auth_r      <= auth_nxt;
    end
  end

  // The name counter never passes the name limit.
  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    name_cnt_r <= NAME_BITS'(MAX_NAME_CHARS))
    else $error("name counter exceeds limit");

  // Trailing whitespace is always part of the counted parameters.
  a_ws_in_params: assert property (@(posedge clk) disable iff (!rst_n)
    ws_cnt_r <= param_cnt_r)
    else $error("trailing whitespace count exceeds parameter count");

  // An error leaves the line either finished or skipping.
  a_error_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.kind == KIND_ERROR) |=>
      (phase_r == PH_START) || (phase_r == PH_SKIP))
    else $error("error did not end or skip the line");

  // A finished line always starts a new one.
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.kind == KIND_DONE) |=> (phase_r == PH_START))
    else $error("line complete without return to line start");

endmodule

FILE: rtl/smtp_clp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP command line parser result register
// Holds one result item for the output channel and packs it into the
// stream fields.
// ----------------------------------------------------------------------------
module smtp_clp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  smtp_clp_pkg::result_t  result,
  output logic                   can_load,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,
  output logic [2:0]             out_tuser
);
  import smtp_clp_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Space when empty or when the held item transfers in this cycle.
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {3'b000, res_r.cause, res_r.code, res_r.trim, res_r.data};

endmodule
